>>> design/svq_pkg.sv
package svq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int IDX_W       = 8;
    localparam int CNT_W       = 9;
    localparam int RING_W      = 16;
    localparam int LG_W        = 4;
    localparam logic [LG_W-1:0] LG_RESET = 4'd8;
    localparam logic [LG_W-1:0] LG_MIN   = 4'd1;
    localparam logic [LG_W-1:0] LG_MAX   = 4'd8;
    localparam logic [IDX_W-1:0] LINK_END = 8'hFF;

    localparam int F_NEXT  = 0;
    localparam int F_WRITE = 1;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_POST    = 2'd1,
        OP_RECLAIM = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_ZERO_LEN = 2'd2,
        ST_NO_USED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [63:0]      addr;
        logic [31:0]      len;
        logic [1:0]       flags;
        logic [IDX_W-1:0] next;
    } desc_t;

    typedef struct packed {
        logic [IDX_W-1:0] id;
        logic [31:0]      len;
    } used_t;

    typedef struct packed {
        logic accept;
        logic dec;
        logic add_wr;
        logic rcl_id;
        logic walk;
        logic load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic add_direct;
        logic used_empty;
        logic walk_more;
        logic clearing;
    } stat_t;

    function automatic logic [LG_W-1:0] sat_lg(input logic [LG_W-1:0] v);
        logic [LG_W-1:0] r;
        r = v;
        if (v < LG_MIN) r = LG_MIN;
        if (v > LG_MAX) r = LG_MAX;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] qsize_of(input logic [LG_W-1:0] lg);
        return CNT_W'(1) << lg;
    endfunction

    function automatic logic [IDX_W-1:0] qmask_of(input logic [LG_W-1:0] lg);
        logic [CNT_W-1:0] s;
        s = (CNT_W'(1) << lg) - CNT_W'(1);
        return s[IDX_W-1:0];
    endfunction

    // free list link of an entry straight after reinitialisation
    function automatic logic [IDX_W-1:0] link_reset(input logic [IDX_W-1:0] i,
                                                    input logic [IDX_W-1:0] qmask);
        return (i == qmask) ? LINK_END : i + IDX_W'(1);
    endfunction

endpackage

>>> design/svq_ram.sv
module svq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/svq_ctrl.sv
module svq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  svq_pkg::stat_t st,
    output svq_pkg::cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DEC    = 6'b000010,
        S_ADD_WR = 6'b000100,
        S_RCL_ID = 6'b001000,
        S_WALK   = 6'b010000,
        S_FIN    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    // hold off requests while the tables are being cleared
    assign s_ready  = (state_reg == S_IDLE) && !st.clearing;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd        = '0;
        cmd.accept = (state_reg == S_IDLE) && s_valid && !st.clearing;
        cmd.dec    = (state_reg == S_DEC);
        cmd.add_wr = (state_reg == S_ADD_WR);
        cmd.rcl_id = (state_reg == S_RCL_ID);
        cmd.walk   = (state_reg == S_WALK);
        cmd.load   = (state_reg == S_FIN) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && !st.clearing) state_next = S_DEC;
            end
            S_DEC: begin
                if (st.op == svq_pkg::OP_ADD && !st.add_direct) begin
                    state_next = S_ADD_WR;
                end else if (st.op == svq_pkg::OP_RECLAIM && !st.used_empty) begin
                    state_next = S_RCL_ID;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_ADD_WR: state_next = S_FIN;
            S_RCL_ID: state_next = S_WALK;
            S_WALK: begin
                if (!st.walk_more) state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.load) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> design/svq_dp.sv
module svq_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [svq_pkg::LG_W-1:0]           cfg_wr_data,
    input  logic [1:0]                         s_op,
    input  logic [63:0]                        s_buf_addr,
    input  logic [31:0]                        s_length,
    input  logic                               s_device_writes,
    input  logic [8:0]                         s_chain_count,
    input  logic [31:0]                        s_cookie,
    input  logic [7:0]                         s_used_id,
    input  svq_pkg::cmd_t                      cmd,
    output svq_pkg::stat_t                     st,
    output logic [1:0]                         m_status,
    output logic [7:0]                         m_desc_index,
    output logic [7:0]                         m_head_index,
    output logic [7:0]                         m_avail_slot,
    output logic                               m_chain_done,
    output logic [31:0]                        m_cookie_out,
    output logic [31:0]                        m_used_len,
    output logic [8:0]                         m_freed_count
);

    localparam int IW = svq_pkg::IDX_W;
    localparam int CW = svq_pkg::CNT_W;
    localparam int RW = svq_pkg::RING_W;
    localparam int QD = svq_pkg::QUEUE_DEPTH;

    // configuration and control state
    logic [svq_pkg::LG_W-1:0] lg_reg;
    logic [IW-1:0] fl_head_reg;
    logic [CW-1:0] free_count_reg;
    logic [RW-1:0] avail_index_reg, used_index_reg, last_used_reg;
    logic [CW-1:0] chain_left_reg;
    logic [IW-1:0] chain_head_reg;
    logic          chain_refused_reg;
    logic          clr_reg;
    logic [IW-1:0] clr_idx_reg;
    logic [IW-1:0] cur_reg;
    logic [CW-1:0] count_reg;

    // latched request
    svq_pkg::op_t  op_reg;
    logic [63:0]   addr_reg;
    logic [31:0]   len_reg;
    logic          wr_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   ck_reg;
    logic [IW-1:0] uid_reg;

    // working result
    svq_pkg::status_t r_status_reg;
    logic [IW-1:0]    r_desc_reg, r_head_reg, r_slot_reg;
    logic             r_done_reg;
    logic [31:0]      r_cookie_reg, r_len_reg;
    logic [CW-1:0]    r_freed_reg;

    logic [IW-1:0] qmask;
    logic [CW-1:0] qsize;
    logic          first, zero_cnt, short, take_first, add_direct;
    logic [IW-1:0] head_cur;

    // memories
    logic [IW-1:0]         fl_rdata, fl_wdata;
    svq_pkg::desc_t        desc_rdata, desc_wdata;
    logic [IW-1:0]         desc_raddr;
    logic                  desc_re;
    logic [31:0]           ck_rdata, ck_wdata;
    logic                  ck_we;
    logic [IW-1:0]         ck_waddr;
    svq_pkg::used_t        used_rdata, used_wdata;

    logic [IW-1:0] add_next_head;
    logic [CW-1:0] add_left;
    logic [IW-1:0] rcl_id;
    logic          walk_nf, walk_more;
    logic [IW-1:0] walk_nx;
    logic [CW:0]   fc_sum;

    assign qmask    = svq_pkg::qmask_of(lg_reg);
    assign qsize    = svq_pkg::qsize_of(lg_reg);
    assign head_cur = fl_head_reg & qmask;

    assign first      = (chain_left_reg == '0);
    assign zero_cnt   = first && (cnt_reg == '0);
    assign short      = first && (cnt_reg > free_count_reg);
    assign take_first = first && !zero_cnt && !short;
    assign add_direct = zero_cnt || short || (!first && chain_refused_reg);

    assign add_next_head = fl_rdata;
    assign add_left      = chain_left_reg - CW'(1);

    assign rcl_id  = used_rdata.id & qmask;
    assign walk_nf = desc_rdata.flags[svq_pkg::F_NEXT];
    assign walk_more = walk_nf && (count_reg < qsize);
    assign walk_nx = desc_rdata.next & qmask;
    assign fc_sum  = {1'b0, free_count_reg} + {1'b0, count_reg};

    assign st.op         = op_reg;
    assign st.add_direct = add_direct;
    assign st.used_empty = (last_used_reg == used_index_reg);
    assign st.walk_more  = walk_more;
    assign st.clearing   = clr_reg;

    assign fl_wdata = clr_reg   ? svq_pkg::link_reset(clr_idx_reg, qmask) :
                      walk_more ? walk_nx : fl_head_reg;

    always_comb begin
        desc_wdata       = '0;
        desc_wdata.addr  = addr_reg;
        desc_wdata.len   = len_reg;
        desc_wdata.flags[svq_pkg::F_NEXT]  = (add_left != '0);
        desc_wdata.flags[svq_pkg::F_WRITE] = wr_reg;
        desc_wdata.next  = add_next_head & qmask;
        if (clr_reg) desc_wdata = '0;
    end

    // store the cookie at the chain head; zero it on the first step of a reclaim walk and when clearing
    assign ck_we    = clr_reg || (cmd.dec && op_reg == svq_pkg::OP_ADD && take_first) ||
                      (cmd.walk && count_reg == CW'(1));
    assign ck_waddr = clr_reg ? clr_idx_reg : (cmd.walk ? r_head_reg : head_cur);
    assign ck_wdata = (clr_reg || cmd.walk) ? '0 : ck_reg;

    assign used_wdata.id  = uid_reg;
    assign used_wdata.len = len_reg;

    assign desc_re    = cmd.rcl_id || (cmd.walk && walk_more);
    assign desc_raddr = cmd.rcl_id ? rcl_id : walk_nx;

    svq_ram #(.WIDTH(IW), .DEPTH(QD)) u_free_link (
        .aclk  (aclk),
        .we    (clr_reg || cmd.walk),
        .waddr (clr_reg ? clr_idx_reg : cur_reg),
        .wdata (fl_wdata),
        .re    (cmd.dec && op_reg == svq_pkg::OP_ADD),
        .raddr (head_cur),
        .rdata (fl_rdata)
    );

    svq_ram #(.WIDTH($bits(svq_pkg::desc_t)), .DEPTH(QD)) u_desc (
        .aclk  (aclk),
        .we    (clr_reg || cmd.add_wr),
        .waddr (clr_reg ? clr_idx_reg : cur_reg),
        .wdata (desc_wdata),
        .re    (desc_re),
        .raddr (desc_raddr),
        .rdata (desc_rdata)
    );

    svq_ram #(.WIDTH(32), .DEPTH(QD)) u_cookie (
        .aclk  (aclk),
        .we    (ck_we),
        .waddr (ck_waddr),
        .wdata (ck_wdata),
        .re    (cmd.rcl_id),
        .raddr (rcl_id),
        .rdata (ck_rdata)
    );

    svq_ram #(.WIDTH($bits(svq_pkg::used_t)), .DEPTH(QD)) u_used (
        .aclk  (aclk),
        .we    (cmd.dec && op_reg == svq_pkg::OP_POST),
        .waddr (used_index_reg[IW-1:0] & qmask),
        .wdata (used_wdata),
        .re    (cmd.dec && op_reg == svq_pkg::OP_RECLAIM),
        .raddr (last_used_reg[IW-1:0] & qmask),
        .rdata (used_rdata)
    );

    // request latch, working result and output register
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= svq_pkg::op_t'(s_op);
            addr_reg     <= s_buf_addr;
            len_reg      <= s_length;
            wr_reg       <= s_device_writes;
            cnt_reg      <= s_chain_count;
            ck_reg       <= s_cookie;
            uid_reg      <= s_used_id;
            r_status_reg <= svq_pkg::ST_OK;
            r_desc_reg   <= '0;
            r_head_reg   <= '0;
            r_slot_reg   <= '0;
            r_done_reg   <= 1'b0;
            r_cookie_reg <= '0;
            r_len_reg    <= '0;
            r_freed_reg  <= '0;
        end
        if (cmd.dec) begin
            cur_reg <= head_cur;
            case (op_reg)
                svq_pkg::OP_ADD: begin
                    if (zero_cnt) begin
                        r_status_reg <= svq_pkg::ST_ZERO_LEN;
                    end else if (add_direct) begin
                        r_status_reg <= svq_pkg::ST_NO_FREE;
                    end
                end
                svq_pkg::OP_POST: r_head_reg <= uid_reg;
                svq_pkg::OP_RECLAIM: begin
                    if (last_used_reg == used_index_reg) begin
                        r_status_reg <= svq_pkg::ST_NO_USED;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.add_wr) begin
            r_desc_reg <= cur_reg;
            r_head_reg <= chain_head_reg;
            if (add_left == '0) begin
                r_slot_reg <= avail_index_reg[IW-1:0] & qmask;
                r_done_reg <= 1'b1;
            end
        end
        if (cmd.rcl_id) begin
            r_head_reg <= rcl_id;
            r_len_reg  <= used_rdata.len;
            cur_reg    <= rcl_id;
            count_reg  <= CW'(1);
        end
        if (cmd.walk) begin
            if (count_reg == CW'(1)) begin
                r_cookie_reg <= ck_rdata;
            end
            if (walk_more) begin
                cur_reg   <= walk_nx;
                count_reg <= count_reg + CW'(1);
            end else begin
                r_freed_reg <= count_reg;
            end
        end
        if (cmd.load) begin
            m_status      <= r_status_reg;
            m_desc_index  <= r_desc_reg;
            m_head_index  <= r_head_reg;
            m_avail_slot  <= r_slot_reg;
            m_chain_done  <= r_done_reg;
            m_cookie_out  <= r_cookie_reg;
            m_used_len    <= r_len_reg;
            m_freed_count <= r_freed_reg;
        end
    end

    // queue state; a size write reinitialises it and starts a clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            lg_reg            <= aresetn ? svq_pkg::sat_lg(cfg_wr_data) : svq_pkg::LG_RESET;
            fl_head_reg       <= '0;
            free_count_reg    <= aresetn ? svq_pkg::qsize_of(svq_pkg::sat_lg(cfg_wr_data))
                                         : svq_pkg::qsize_of(svq_pkg::LG_RESET);
            avail_index_reg   <= '0;
            used_index_reg    <= '0;
            last_used_reg     <= '0;
            chain_left_reg    <= '0;
            chain_head_reg    <= '0;
            chain_refused_reg <= 1'b0;
            clr_reg           <= 1'b1;
            clr_idx_reg       <= '0;
        end else begin
            if (clr_reg) begin
                clr_idx_reg <= clr_idx_reg + IW'(1);
                if (clr_idx_reg == IW'(QD - 1)) clr_reg <= 1'b0;
            end
            if (cmd.dec) begin
                case (op_reg)
                    svq_pkg::OP_ADD: begin
                        if (short) begin
                            chain_left_reg    <= cnt_reg - CW'(1);
                            chain_refused_reg <= (cnt_reg != CW'(1));
                        end else if (!first && chain_refused_reg) begin
                            chain_left_reg    <= add_left;
                            chain_refused_reg <= (add_left != '0);
                        end else if (take_first) begin
                            chain_refused_reg <= 1'b0;
                            chain_head_reg    <= head_cur;
                            chain_left_reg    <= cnt_reg;
                        end
                    end
                    svq_pkg::OP_POST: used_index_reg <= used_index_reg + RW'(1);
                    default: ;
                endcase
            end
            if (cmd.add_wr) begin
                fl_head_reg    <= add_next_head;
                chain_left_reg <= add_left;
                if (free_count_reg != '0) free_count_reg <= free_count_reg - CW'(1);
                if (add_left == '0) avail_index_reg <= avail_index_reg + RW'(1);
            end
            if (cmd.walk) begin
                if (!walk_more) begin
                    fl_head_reg    <= r_head_reg;
                    free_count_reg <= (fc_sum > {1'b0, qsize}) ? qsize : fc_sum[CW-1:0];
                    last_used_reg  <= last_used_reg + RW'(1);
                end
            end
        end
    end

endmodule

>>> design/split_virtqueue_descriptor_manager.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    op, buf_addr, length, device_writes, chain_count,
//                                   cookie, used_id
// m_        out  m_valid/m_ready    status, desc_index, head_index, avail_slot,
//                                   chain_done, cookie_out, used_len, freed_count
// cfg_      in   cfg_wr_en          cfg_wr_data = queue_size_log2
//
// One request at a time. Post, no-op, refused add and empty reclaim go from decode
// straight to the result; an accepted add first writes its descriptor.
// Reclaim reads the used ring, then walks a chain of n descriptors, one descriptor-table read
// a cycle. A new request is taken while a result waits in the output register; the
// result of that request holds until m_ready frees the register.
// Reset and size writes start a clearing pass over all 256 entries; s_ready stays low until done.
module split_virtqueue_descriptor_manager (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [63:0] s_buf_addr,
    input  logic [31:0] s_length,
    input  logic        s_device_writes,
    input  logic [8:0]  s_chain_count,
    input  logic [31:0] s_cookie,
    input  logic [7:0]  s_used_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_desc_index,
    output logic [7:0]  m_head_index,
    output logic [7:0]  m_avail_slot,
    output logic        m_chain_done,
    output logic [31:0] m_cookie_out,
    output logic [31:0] m_used_len,
    output logic [8:0]  m_freed_count
);

    svq_pkg::cmd_t  cmd;
    svq_pkg::stat_t st;

    svq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    svq_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_op            (s_op),
        .s_buf_addr      (s_buf_addr),
        .s_length        (s_length),
        .s_device_writes (s_device_writes),
        .s_chain_count   (s_chain_count),
        .s_cookie        (s_cookie),
        .s_used_id       (s_used_id),
        .cmd             (cmd),
        .st              (st),
        .m_status        (m_status),
        .m_desc_index    (m_desc_index),
        .m_head_index    (m_head_index),
        .m_avail_slot    (m_avail_slot),
        .m_chain_done    (m_chain_done),
        .m_cookie_out    (m_cookie_out),
        .m_used_len      (m_used_len),
        .m_freed_count   (m_freed_count)
    );

`ifndef SYNTHESIS
    a_accept_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.dec)
        else $error("accepted request not decoded");

    a_walk_op: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> (st.op == svq_pkg::OP_RECLAIM))
        else $error("chain walk outside reclaim");

    a_add_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_wr |-> (st.op == svq_pkg::OP_ADD) && $past(cmd.dec))
        else $error("descriptor write without free-list lookup");
`endif

endmodule
